/* rtl/core/mandelbrot_escape_time_pixel_assert.svh */
// Assertion macros for the escape-time pixel block.
// Both expect clk and rst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH

// cond holds at every edge out of reset
`define MET_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at one edge implies cons at the next
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/met_pkg.sv */
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, register indexes and types of the escape-time pixel block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package met_pkg;

    localparam int ZW      = 64;  // internal fixed-point word
    localparam int COORD_W = 32;  // Q4.28 register width
    localparam int IDX_W   = 12;  // row / column width
    localparam int ITER_W  = 12;  // iterations field width
    localparam int COLOR_W = 32;
    localparam int QDEPTH  = 2;

    localparam logic [2:0] REG_MIN_RE   = 3'd0;
    localparam logic [2:0] REG_MIN_IM   = 3'd1;
    localparam logic [2:0] REG_RE_STEP  = 3'd2;
    localparam logic [2:0] REG_IM_STEP  = 3'd3;
    localparam logic [2:0] REG_MAX_ITER = 3'd4;

    localparam logic [ZW-1:0] SAT_MAG = 64'h2000_0000_0000_0000;
    localparam logic [7:0]    ALPHA   = 8'hFF;

    typedef struct packed {
        logic signed [ZW-1:0] cx;
        logic signed [ZW-1:0] cy;
    } coord_t;

endpackage

/* rtl/core/met_mul.sv */
// ----------------------------------------------------------------------------
// met_mul
// Signed 64x64 fixed-point multiply over four 32x32 partial products,
// shift right by SHIFT toward zero, saturate the magnitude to 2^61.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_mul
    import met_pkg::*;
#(
    parameter int SHIFT = 28
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [ZW-1:0] a,
    input  logic signed [ZW-1:0] b,
    output logic                 done,
    output logic signed [ZW-1:0] result
);

    logic [2:0]        cnt_reg;
    logic              done_reg;
    logic [ZW-1:0]     mag_a_reg;
    logic [ZW-1:0]     mag_b_reg;
    logic              neg_reg;
    logic [ZW-1:0]     pp_reg;
    logic [1:0]        pos_reg;
    logic [2*ZW-1:0]   acc_reg;
    logic signed [ZW-1:0] res_reg;

    logic [1:0]        k;
    logic [31:0]       half_a;
    logic [31:0]       half_b;
    logic [1:0]        pos;
    logic [2*ZW-1:0]   shifted;
    logic [ZW-1:0]     sat;
    logic              idle;

    assign idle   = (cnt_reg == 3'd0);
    assign k      = 2'(cnt_reg - 3'd1);
    assign half_a = k[0] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign half_b = k[1] ? mag_b_reg[63:32] : mag_b_reg[31:0];
    assign pos    = {1'b0, k[0]} + {1'b0, k[1]};

    always_comb
    begin
        shifted = acc_reg >> SHIFT;
        if (shifted > {{ZW{1'b0}}, SAT_MAG})
        begin
            sat = SAT_MAG;
        end
        else
        begin
            sat = shifted[ZW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 3'd6);
            if (idle && start)
            begin
                cnt_reg <= 3'd1;
            end
            else if (!idle)
            begin
                cnt_reg <= (cnt_reg == 3'd6) ? 3'd0 : cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (idle && start)
        begin
            mag_a_reg <= a[ZW-1] ? ZW'(-a) : ZW'(a);
            mag_b_reg <= b[ZW-1] ? ZW'(-b) : ZW'(b);
            neg_reg   <= a[ZW-1] ^ b[ZW-1];
            acc_reg   <= '0;
        end
        else
        begin
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
            begin
                pp_reg  <= half_a * half_b;
                pos_reg <= pos;
            end
            if (cnt_reg >= 3'd2 && cnt_reg <= 3'd5)
            begin
                acc_reg <= acc_reg + ({{ZW{1'b0}}, pp_reg} << {pos_reg, 5'b0});
            end
            if (cnt_reg == 3'd6)
            begin
                res_reg <= neg_reg ? -$signed(sat) : $signed(sat);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/met_div.sv */
// ----------------------------------------------------------------------------
// met_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_div
#(
    parameter int NW = 20,
    parameter int DW = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (cnt_reg == '0 && start)
            begin
                cnt_reg <= CW'(NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // dividend shifts out of the top while quotient bits enter the bottom
    always_ff @(posedge clk)
    begin
        if (cnt_reg == '0 && start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* rtl/core/met_queue.sv */
// ----------------------------------------------------------------------------
// met_queue
// Two-entry request queue between the coordinate front end and the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_queue
    import met_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  coord_t wr_data,
    output logic   rd_valid,
    input  logic   rd_pop,
    output coord_t rd_data
);

    coord_t     mem [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'(QDEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/met_front.sv */
// ----------------------------------------------------------------------------
// met_front
// Accepts pixel requests and forms c from edge, step and index:
// multiply, then add, saturate to Q4.28 and rescale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_front
    import met_pkg::*;
#(
    parameter int FRAC_BITS = 28
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IDX_W-1:0]          row,
    input  logic [IDX_W-1:0]          col,
    input  logic signed [COORD_W-1:0] min_re,
    input  logic signed [COORD_W-1:0] min_im,
    input  logic signed [COORD_W-1:0] re_step,
    input  logic signed [COORD_W-1:0] im_step,
    output logic                      out_valid,
    input  logic                      out_ready,
    output coord_t                    out_data
);

    localparam int UP = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
    localparam int DN = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
    localparam logic [ZW-1:0] RND = (ZW'(1) << DN) - ZW'(1);
    localparam int PW = IDX_W + 1 + COORD_W;

    logic                 s1_valid_reg;
    logic signed [PW-1:0] p_re_reg;
    logic signed [PW-1:0] p_im_reg;
    logic                 out_valid_reg;
    coord_t               out_data_reg;
    logic                 adv2;
    logic signed [PW-1:0] p_re;
    logic signed [PW-1:0] p_im;

    function automatic logic signed [ZW-1:0] to_internal(
        input logic signed [COORD_W-1:0] base,
        input logic signed [PW-1:0]      prod
    );
        logic signed [PW:0]   sum;
        logic signed [ZW-1:0] v;
        logic                 neg;
        logic [ZW-1:0]        mag;
        logic [ZW-1:0]        sh;
        logic signed [ZW-1:0] r;
        sum = $signed({{(PW + 1 - COORD_W){base[COORD_W-1]}}, base})
            + $signed({prod[PW-1], prod});
        if (sum > $signed((PW + 1)'(32'sh7FFF_FFFF)))
        begin
            v = ZW'(32'sh7FFF_FFFF);
        end
        else if (sum < -$signed((PW + 1)'(33'sh0_8000_0000)))
        begin
            v = -$signed(ZW'(33'sh0_8000_0000));
        end
        else
        begin
            v = ZW'(sum);
        end
        // negative values round away from zero on the way down
        neg = v[ZW-1];
        mag = neg ? ZW'(-v) : ZW'(v);
        sh  = (mag + (neg ? RND : '0)) >> DN;
        r   = neg ? -$signed(sh) : $signed(sh);
        return r <<< UP;
    endfunction

    assign adv2     = !out_valid_reg || out_ready;
    assign s_tready = !s1_valid_reg || adv2;
    assign p_re     = $signed({1'b0, col}) * re_step;
    assign p_im     = $signed({1'b0, row}) * im_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            p_re_reg <= p_re;
            p_im_reg <= p_im;
        end
        if (adv2)
        begin
            out_data_reg.cx <= to_internal(min_re, p_re_reg);
            out_data_reg.cy <= to_internal(min_im, p_im_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/core/met_back.sv */
// ----------------------------------------------------------------------------
// met_back
// Escape-time engine: z = z^2 + c on three multiply units, then the
// palette scale divide and the six-sector hue ramp into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module met_back
    import met_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  coord_t                q_data,
    input  logic [COUNT_BITS-1:0] limit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ITER_W-1:0]     out_iter,
    output logic [COLOR_W-1:0]    out_color
);

    localparam int NW = COUNT_BITS + 8;
    localparam logic signed [ZW-1:0] FOUR = ZW'(4) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_MXY,
        ST_MSQ,
        ST_DIV,
        ST_HUE
    } state_t;

    state_t                state_reg;
    logic signed [ZW-1:0]  zx_reg;
    logic signed [ZW-1:0]  zy_reg;
    logic signed [ZW-1:0]  xsq_reg;
    logic signed [ZW-1:0]  ysq_reg;
    logic signed [ZW-1:0]  cx_reg;
    logic signed [ZW-1:0]  cy_reg;
    logic [COUNT_BITS-1:0] t_reg;
    logic                  sqx_go_reg;
    logic                  sqy_go_reg;
    logic [7:0]            v_reg;
    logic                  out_valid_reg;
    logic [ITER_W-1:0]     out_iter_reg;
    logic [COLOR_W-1:0]    out_color_reg;

    logic                  go_on;
    logic                  xy_start;
    logic                  div_start;
    logic                  xy_done;
    logic                  sqx_done;
    logic                  sqy_done;
    logic signed [ZW-1:0]  xy_res;
    logic signed [ZW-1:0]  sqx_res;
    logic signed [ZW-1:0]  sqy_res;
    logic                  div_done;
    logic [NW-1:0]         quo;
    logic [NW-1:0]         num;

    function automatic logic [COLOR_W-1:0] hue(input logic [7:0] v);
        logic [10:0] h;
        logic [7:0]  f;
        logic [7:0]  fi;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        h  = 11'(v) * 11'd6;
        f  = h[7:0];
        fi = 8'hFF - f;
        case (h[10:8])
            3'd0:
            begin
                r = 8'hFF; g = f;     b = 8'h00;
            end
            3'd1:
            begin
                r = fi;    g = 8'hFF; b = 8'h00;
            end
            3'd2:
            begin
                r = 8'h00; g = 8'hFF; b = f;
            end
            3'd3:
            begin
                r = 8'h00; g = fi;    b = 8'hFF;
            end
            3'd4:
            begin
                r = f;     g = 8'h00; b = 8'hFF;
            end
            default:
            begin
                r = 8'hFF; g = 8'h00; b = fi;
            end
        endcase
        return {ALPHA, b, g, r};
    endfunction

    assign go_on     = (t_reg < limit) && ((xsq_reg + ysq_reg) <= FOUR);
    assign xy_start  = (state_reg == ST_TEST) && go_on;
    assign div_start = (state_reg == ST_TEST) && !go_on;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    // t * 255
    assign num       = {t_reg, 8'b0} - NW'(t_reg);

    met_mul #(.SHIFT(FRAC_BITS - 1)) u_mul_xy
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (xy_start),
        .a      (zx_reg),
        .b      (zy_reg),
        .done   (xy_done),
        .result (xy_res)
    );

    met_mul #(.SHIFT(FRAC_BITS)) u_mul_sqx
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqx_go_reg),
        .a      (zx_reg),
        .b      (zx_reg),
        .done   (sqx_done),
        .result (sqx_res)
    );

    met_mul #(.SHIFT(FRAC_BITS)) u_mul_sqy
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqy_go_reg),
        .a      (zy_reg),
        .b      (zy_reg),
        .done   (sqy_done),
        .result (sqy_res)
    );

    met_div #(.NW(NW), .DW(COUNT_BITS)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (limit),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zx_reg        <= '0;
            zy_reg        <= '0;
            xsq_reg       <= '0;
            ysq_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            t_reg         <= '0;
            sqx_go_reg    <= 1'b0;
            sqy_go_reg    <= 1'b0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_iter_reg  <= '0;
            out_color_reg <= '0;
        end
        else
        begin
            // zx^2 starts once the new zx is in place, zy^2 once zy is
            sqx_go_reg <= xy_start;
            sqy_go_reg <= (state_reg == ST_MXY) && xy_done;
            if (out_ready && state_reg != ST_HUE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (sqx_done)
            begin
                xsq_reg <= sqx_res;
            end
            if (sqy_done)
            begin
                ysq_reg <= sqy_res;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cx_reg    <= q_data.cx;
                        cy_reg    <= q_data.cy;
                        zx_reg    <= '0;
                        zy_reg    <= '0;
                        xsq_reg   <= '0;
                        ysq_reg   <= '0;
                        t_reg     <= '0;
                        state_reg <= ST_TEST;
                    end
                end
                ST_TEST:
                begin
                    if (go_on)
                    begin
                        // zx*zy latches the old zx at this edge
                        zx_reg     <= xsq_reg - ysq_reg + cx_reg;
                        state_reg  <= ST_MXY;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_MXY:
                begin
                    if (xy_done)
                    begin
                        zy_reg     <= xy_res + cy_reg;
                        state_reg  <= ST_MSQ;
                    end
                end
                ST_MSQ:
                begin
                    if (sqy_done)
                    begin
                        t_reg     <= t_reg + COUNT_BITS'(1);
                        state_reg <= ST_TEST;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        v_reg     <= (limit == '0) ? 8'd0 : quo[7:0];
                        state_reg <= ST_HUE;
                    end
                end
                ST_HUE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_iter_reg  <= ITER_W'(t_reg);
                        out_color_reg <= hue(v_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_iter  = out_iter_reg;
    assign out_color = out_color_reg;

endmodule

/* rtl/core/mandelbrot_escape_time_pixel.sv */
// Each iteration runs zx*zy and zx^2 on their own multiply units, then zy^2
// once zy is known, each product four 32x32 partial products. The palette
// scale divide then runs NW = COUNT_BITS + 8 divider steps. The engine works on
// one pixel at a time; a two-entry queue takes more requests meanwhile.
// Reset is asynchronous, active low; the configuration registers return to
// the default view.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time count and hue-palette colour for one pixel per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel
    import met_pkg::*;
#(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row [11:0], col [23:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // iterations [11:0], color [43:12], zero [47:44]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [COORD_W-1:0] min_re_reg;
    logic signed [COORD_W-1:0] min_im_reg;
    logic signed [COORD_W-1:0] re_step_reg;
    logic signed [COORD_W-1:0] im_step_reg;
    logic [COUNT_BITS-1:0]     max_iter_reg;

    logic                      f_valid;
    logic                      f_ready;
    coord_t                    f_data;
    logic                      q_valid;
    logic                      q_pop;
    coord_t                    q_data;
    logic [ITER_W-1:0]         iter;
    logic [COLOR_W-1:0]        color;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_re_reg   <= -32'sd536870912;
            min_im_reg   <= -32'sd402653184;
            re_step_reg  <= 32'sd786432;
            im_step_reg  <= 32'sd786432;
            max_iter_reg <= COUNT_BITS'(255);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_RE:   min_re_reg   <= cfg_data;
                REG_MIN_IM:   min_im_reg   <= cfg_data;
                REG_RE_STEP:  re_step_reg  <= cfg_data;
                REG_IM_STEP:  im_step_reg  <= cfg_data;
                REG_MAX_ITER: max_iter_reg <= COUNT_BITS'(cfg_data[11:0]);
                default:
                begin
                end
            endcase
        end
    end

    met_front #(.FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .row       (s_tdata[11:0]),
        .col       (s_tdata[23:12]),
        .min_re    (min_re_reg),
        .min_im    (min_im_reg),
        .re_step   (re_step_reg),
        .im_step   (im_step_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    met_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    met_back #(.FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .limit     (max_iter_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_iter  (iter),
        .out_color (color)
    );

    assign m_tdata = {4'b0, color, iter};

endmodule

/* rtl/core/met_checker.sv */
// ----------------------------------------------------------------------------
// met_checker
// Port-level checks on the escape-time pixel block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_assert.svh"

module met_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_data
);

    `MET_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port stalled")
    `MET_ASSERT_ALWAYS(a_alpha, !m_tvalid || m_tdata[43:36] == 8'hFF, "alpha not opaque")
    `MET_ASSERT_ALWAYS(a_pad, !m_tvalid || m_tdata[47:44] == 4'h0, "pad bits set")
    `MET_ASSERT_ALWAYS(a_hue_peak, !m_tvalid || m_tdata[19:12] == 8'hFF || m_tdata[27:20] == 8'hFF || m_tdata[35:28] == 8'hFF, "no channel at full scale")
    `MET_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);

/* tb/mandelbrot_escape_time_pixel_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb
// Checks escape counts and hue colours against an in-bench fixed-point
// predictor. It covers register extremes, coordinate saturation, a zero limit
// and random views, with random stalls on both streams.
// ----------------------------------------------------------------------------

module mandelbrot_escape_time_pixel_tb;
    import met_pkg::*;

    localparam int FRAC       = 28;
    localparam int WDOG_LIMIT = 300000;
    localparam int HOLD_LEN   = 30000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;     // row [11:0], col [23:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;     // iterations [11:0], color [43:12]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    bit no_idle;
    bit hold_req;
    int wdog;

    mandelbrot_escape_time_pixel uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    class pixel_scoreboard;
        logic signed [31:0] min_re, min_im, re_step, im_step;
        logic [11:0]        limit;
        logic [43:0]        pending_px[$];   // {color, iterations}
        int                 mismatches;

        function new();
            min_re     = -32'sd536870912;
            min_im     = -32'sd402653184;
            re_step    = 32'sd786432;
            im_step    = 32'sd786432;
            limit      = 12'd255;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_MIN_RE:   min_re  = d;
                REG_MIN_IM:   min_im  = d;
                REG_RE_STEP:  re_step = d;
                REG_IM_STEP:  im_step = d;
                REG_MAX_ITER: limit   = d[11:0];
                default: ;
            endcase
        endfunction

        // edge + index*step, clipped to the Q4.28 register range
        function longint coord_q(logic signed [31:0] base, logic signed [31:0] step,
                                 logic [11:0] idx);
            longint v;
            v = longint'(base) + longint'(idx) * longint'(step);
            if (v > 64'sd2147483647)  v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v;
        endfunction

        // exact product, magnitude truncated then clipped to 2^61
        function longint fx_mul(longint a, longint b, int sh);
            logic [63:0]  ua, ub, r;
            logic [127:0] p;
            bit           neg;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            p   = {64'b0, ua} * {64'b0, ub};
            p   = p >> sh;
            r   = (p > {64'b0, SAT_MAG}) ? SAT_MAG : p[63:0];
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function logic [31:0] hue(int unsigned v);
            int unsigned h, f, fi;
            logic [7:0]  r, g, b;
            h  = (v & 8'hFF) * 6;
            f  = h & 8'hFF;
            fi = 255 - f;
            case (h >> 8)
                0:       begin r = 255; g = f;   b = 0;   end
                1:       begin r = fi;  g = 255; b = 0;   end
                2:       begin r = 0;   g = 255; b = f;   end
                3:       begin r = 0;   g = fi;  b = 255; end
                4:       begin r = f;   g = 0;   b = 255; end
                default: begin r = 255; g = 0;   b = fi;  end
            endcase
            return {ALPHA, b, g, r};
        endfunction

        function void note(logic [11:0] row, logic [11:0] col);
            longint      cx, cy, zx, zy, xsq, ysq, four;
            int unsigned t, v;
            cx   = coord_q(min_re, re_step, col);
            cy   = coord_q(min_im, im_step, row);
            four = 64'sd4 <<< FRAC;
            zx = 0; zy = 0; xsq = 0; ysq = 0; t = 0;
            while (t < limit && xsq + ysq <= four) begin
                zy  = fx_mul(zx, zy, FRAC - 1) + cy;
                zx  = xsq - ysq + cx;
                xsq = fx_mul(zx, zx, FRAC);
                ysq = fx_mul(zy, zy, FRAC);
                t++;
            end
            v = (limit == 0) ? 0 : (t * 255) / limit;
            pending_px.push_back({hue(v), t[11:0]});
        endfunction

        function void check(logic [47:0] d);
            logic [43:0] exp_px;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: iterations %0d color %h", d[11:0], d[43:12]);
                return;
            end
            exp_px = pending_px.pop_front();
            if (d[11:0] !== exp_px[11:0] || d[43:12] !== exp_px[43:12]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: iterations exp %0d got %0d, color exp %h got %h",
                             exp_px[11:0], d[11:0], exp_px[43:12], d[43:12]);
            end
        endfunction

        function int pending();
            return pending_px.size();
        endfunction
    endclass

    pixel_scoreboard sb = new();

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // receiver: random back-pressure bursts, and one long hold-off on request
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 0;
                m_tready = 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 10);
                m_tready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (m_tvalid && m_tready)
                sb.check(m_tdata);
            if (wdog >= WDOG_LIMIT)
            begin
                $display("mandelbrot_escape_time_pixel_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, d);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] row, logic [11:0] col);
        int n;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 10);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        else
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {col, row};
        do @(posedge clk); while (!s_tready);
        sb.note(row, col);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_view();
        if ($urandom_range(0, 5) == 0)
        begin
            write_reg(REG_MIN_RE, $urandom());
            write_reg(REG_MIN_IM, $urandom());
            write_reg(REG_RE_STEP, $urandom());
            write_reg(REG_IM_STEP, $urandom());
        end
        else
        begin
            // a window around the set, small steps so most points stay in view
            write_reg(REG_MIN_RE, -32'sd671088640 + $urandom_range(0, 402653184));
            write_reg(REG_MIN_IM, -32'sd402653184 + $urandom_range(0, 268435456));
            write_reg(REG_RE_STEP, $urandom_range(0, 1 << 19) - (1 << 16));
            write_reg(REG_IM_STEP, $urandom_range(0, 1 << 19) - (1 << 16));
        end
        write_reg(REG_MAX_ITER, ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 48));
    endtask

    initial
    begin
        logic [11:0] r, c;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_RE;
        cfg_data  = '0;
        no_idle   = 0;
        hold_req  = 0;
        wdog      = 0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset view: corners, and two points that never escape, one next to the origin
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd512, 12'd683);
        send_pixel(12'd400, 12'd500);
        drain();

        // extreme edges and steps: coordinates clip to the register range
        write_reg(REG_MIN_RE, 32'h8000_0000);
        write_reg(REG_MIN_IM, 32'h7FFF_FFFF);
        write_reg(REG_RE_STEP, 32'h7FFF_FFFF);
        write_reg(REG_IM_STEP, 32'h8000_0000);
        write_reg(REG_MAX_ITER, 32'd4095);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1, 12'd2);
        drain();

        // c = 0 runs the full largest limit; c = -2 then runs the full limit of 1
        write_reg(REG_MIN_RE, 32'd0);
        write_reg(REG_MIN_IM, 32'd0);
        write_reg(REG_RE_STEP, 32'd0);
        write_reg(REG_IM_STEP, 32'd0);
        send_pixel(12'd7, 12'd9);
        drain();
        write_reg(REG_MIN_RE, 32'hE000_0000);
        write_reg(REG_MAX_ITER, 32'd1);
        send_pixel(12'd0, 12'd0);
        drain();

        // wide write leaving a zero limit; unknown indexes are ignored
        write_reg(REG_MAX_ITER, 32'hFFFF_F000);
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'h1234_5678);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_pixel(12'd3, 12'd4);
        send_pixel(12'd4095, 12'd4095);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            random_view();
            if (ph == 2)
                hold_req = 1;
            if (ph == 7)
                no_idle = 1;
            for (int i = 0; i < 78; i++)
            begin
                r = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300);
                c = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300);
                send_pixel(r, c);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("mandelbrot_escape_time_pixel_tb: PASS");
        else
            $display("mandelbrot_escape_time_pixel_tb: FAIL");
        $finish;
    end

endmodule

/* mandelbrot_escape_time_pixel.f */
+incdir+rtl/core
rtl/core/met_pkg.sv
rtl/core/met_mul.sv
rtl/core/met_div.sv
rtl/core/met_queue.sv
rtl/core/met_front.sv
rtl/core/met_back.sv
rtl/core/mandelbrot_escape_time_pixel.sv
rtl/core/met_checker.sv
tb/mandelbrot_escape_time_pixel_tb.sv
